### sv/plt_pkg.sv
// shared types and constants for the piecewise linear table interpolator
package plt_pkg;

    // default sizes
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_VALUE_WIDTH = 32;

    // fixed field widths
    localparam int POS_W     = 32;
    localparam int MAG_W     = POS_W + 1;
    localparam int IDX_W     = 8;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 1;

    // register reset values
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_THRESHOLD = 1'b1;

    // input item kinds
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // shared add/subtract unit operation
    typedef enum logic {
        OP_ADD,
        OP_SUB
    } alu_op_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_QCHK,
        ST_SRCH_ADDR,
        ST_SRCH_CMP,
        ST_RD_J,
        ST_RD_K,
        ST_LD_K,
        ST_DQ_P,
        ST_DQ_N,
        ST_DR_P,
        ST_DR_N,
        ST_DV_P,
        ST_DV_N,
        ST_MUL,
        ST_DIV_CHK,
        ST_DIV,
        ST_FINAL,
        ST_CLAMP_RD,
        ST_CLAMP_LD,
        ST_OUT
    } state_t;

endpackage

### sv/plt_mem.sv
// breakpoint and value table: one write port, one registered read port
module plt_mem
    import plt_pkg::*;
#(
    parameter int DEPTH  = DEF_TABLE_DEPTH,
    parameter int DATA_W = POS_W + DEF_VALUE_WIDTH,
    parameter int ADDR_W = $clog2(DEF_TABLE_DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write on load, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/plt_addsub.sv
// shared add/subtract unit with carry out (carry high on subtract means a >= b)
module plt_addsub
    import plt_pkg::*;
#(
    parameter int W = DEF_VALUE_WIDTH + 3
)
(
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  alu_op_t      op,
    output logic [W-1:0] sum,
    output logic         carry
);

    logic         is_sub;
    logic [W-1:0] b_eff;
    logic [W:0]   full;

    // subtract as add of the complement plus one
    assign is_sub = (op == OP_SUB);
    assign b_eff  = is_sub ? ~b : b;
    assign full   = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, is_sub};
    assign sum    = full[W-1:0];
    assign carry  = full[W];

endmodule

### sv/piecewise_linear_table_interp.sv
// piecewise linear table interpolator: bisection search, shift-add multiply, restoring divide
// load: no result; clamped query: result goes through the QCHK, CLAMP_RD, CLAMP_LD and OUT states
// other query: bisection, differences, multiply, divide; s = bisection steps (about log2 of entry_count)
//   equal breakpoints skip the multiply and divide; overflow skips the divide
// one item at a time; query time is set by the 33-step multiply and VALUE_WIDTH-step divide
//   on the single add/subtract unit and one table read per bisection step
// reset sets control and configuration to their reset values; table contents undefined until loaded
module piecewise_linear_table_interp
    import plt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 s_tvalid,
    output logic                                                 s_tready,
    // entry_index, entry_position, entry_value, query_position
    input  logic [((IDX_W+2*POS_W+VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,
    // action
    input  logic                                                 s_tuser,
    output logic                                                 m_tvalid,
    input  logic                                                 m_tready,
    // result_value
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]                     m_tdata,
    // clamped, saturated
    output logic [1:0]                                           m_tuser,
    input  logic                                                 cfg_valid,
    output logic                                                 cfg_ready,
    input  logic [CFG_IDX_W-1:0]                                 cfg_index,
    input  logic [POS_W-1:0]                                     cfg_data
);

    localparam int VW        = VALUE_WIDTH;
    localparam int AW        = $clog2(TABLE_DEPTH);
    localparam int DW        = POS_W + VW;
    localparam int UW        = ((VW + 1 > MAG_W + 1) ? VW + 1 : MAG_W + 1) + 1;
    localparam int PW        = VW + 1 + MAG_W;
    localparam int OUT_W     = ((VW + 7) / 8) * 8;
    localparam int MAX_STEPS = (MAG_W > VW) ? MAG_W : VW;
    localparam int CNTW      = $clog2(MAX_STEPS + 1);
    localparam int CW        = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
    localparam int OFS_POS   = IDX_W;
    localparam int OFS_VAL   = IDX_W + POS_W;
    localparam int OFS_Q     = IDX_W + POS_W + VW;

    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    // input fields
    logic [IDX_W-1:0] in_index;
    logic [POS_W-1:0] in_pos;
    logic [VW-1:0]    in_val;
    logic [POS_W-1:0] in_q;

    assign in_index = s_tdata[IDX_W-1:0];
    assign in_pos   = s_tdata[OFS_VAL-1:OFS_POS];
    assign in_val   = s_tdata[OFS_Q-1:OFS_VAL];
    assign in_q     = s_tdata[OFS_Q+POS_W-1:OFS_Q];

    // control and datapath registers
    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] cfg_count_reg;
    logic [POS_W-1:0]   cfg_thr_reg;
    logic [POS_W-1:0]   q_reg;
    logic [AW-1:0]      j_reg, k_reg;
    logic [POS_W-1:0]   bpj_reg, bpk_reg;
    logic [VW-1:0]      vj_reg, vk_reg;
    logic [UW-1:0]      tmp_reg;
    logic               neg_reg;
    logic [MAG_W-1:0]   mag_dq_reg, mag_dr_reg;
    logic [VW:0]        mag_dv_reg;
    logic [PW-1:0]      prod_reg;
    logic [MAG_W-1:0]   rem_reg;
    logic [VW-1:0]      dvd_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic [VW-1:0]      res_reg;
    logic               res_clamp_reg, res_sat_reg;
    logic               out_valid_reg;
    logic [VW-1:0]      out_value_reg;
    logic               out_clamp_reg, out_sat_reg;

    // transfers
    logic in_xfer, load_xfer, query_xfer, idx_ok, mem_we, out_load;

    assign in_xfer    = s_tvalid && s_tready;
    assign load_xfer  = in_xfer && (s_tuser == ACT_LOAD);
    assign query_xfer = in_xfer && (s_tuser == ACT_QUERY);
    assign idx_ok     = 32'(in_index) < 32'(TABLE_DEPTH);
    assign mem_we     = load_xfer && idx_ok;
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);
    assign cfg_ready  = 1'b1;

    // last entry index from entry_count, held to the table range
    logic [CW-1:0] count_ext;
    logic [AW-1:0] nm1;

    assign count_ext = CW'(cfg_count_reg);

    always_comb
    begin
        if (count_ext < CW'(2))
        begin
            nm1 = AW'(1);
        end
        else if (count_ext > CW'(TABLE_DEPTH))
        begin
            nm1 = AW'(TABLE_DEPTH - 1);
        end
        else
        begin
            nm1 = AW'(count_ext - CW'(1));
        end
    end

    // bisection midpoint and bracket width
    logic [AW:0]   jk_sum;
    logic [AW-1:0] mid, gap;

    assign jk_sum = {1'b0, j_reg} + {1'b0, k_reg};
    assign mid    = jk_sum[AW:1];
    assign gap    = k_reg - j_reg;

    // table memory
    logic [AW-1:0]    rd_addr;
    logic [DW-1:0]    rd_data;
    logic [POS_W-1:0] rd_pos;
    logic [VW-1:0]    rd_val;

    plt_mem #(
        .DEPTH  (TABLE_DEPTH),
        .DATA_W (DW),
        .ADDR_W (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(in_index)),
        .wdata ({in_val, in_pos}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_pos = rd_data[POS_W-1:0];
    assign rd_val = rd_data[DW-1:POS_W];

    // shared add/subtract unit
    logic [UW-1:0] alu_a, alu_b, alu_sum;
    alu_op_t       alu_op;
    logic          alu_carry;

    plt_addsub #(
        .W (UW)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .op    (alu_op),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // magnitude picked from the two difference passes
    logic [MAG_W-1:0] sel_mag;
    logic [VW:0]      sel_mag_dv;
    logic             in_range;

    assign sel_mag    = tmp_reg[UW-1] ? alu_sum[MAG_W-1:0] : tmp_reg[MAG_W-1:0];
    assign sel_mag_dv = tmp_reg[UW-1] ? alu_sum[VW:0] : tmp_reg[VW:0];
    assign in_range   = (&alu_sum[UW-1:VW-1]) || !(|alu_sum[UW-1:VW-1]);

    // sign-extended values for the unit
    logic [UW-1:0] vj_ext, vk_ext;

    assign vj_ext = {{(UW-VW){vj_reg[VW-1]}}, vj_reg};
    assign vk_ext = {{(UW-VW){vk_reg[VW-1]}}, vk_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (query_xfer) state_next = ST_QCHK;
            ST_QCHK:      state_next = alu_carry ? ST_SRCH_ADDR : ST_CLAMP_RD;
            ST_SRCH_ADDR: state_next = (gap > AW'(1)) ? ST_SRCH_CMP : ST_RD_J;
            ST_SRCH_CMP:  state_next = ST_SRCH_ADDR;
            ST_RD_J:      state_next = ST_RD_K;
            ST_RD_K:      state_next = ST_LD_K;
            ST_LD_K:      state_next = ST_DQ_P;
            ST_DQ_P:      state_next = ST_DQ_N;
            ST_DQ_N:      state_next = ST_DR_P;
            ST_DR_P:      state_next = ST_DR_N;
            ST_DR_N:      state_next = (sel_mag == '0) ? ST_FINAL : ST_DV_P;
            ST_DV_P:      state_next = ST_DV_N;
            ST_DV_N:      state_next = ST_MUL;
            ST_MUL:       if (cnt_reg == '0) state_next = ST_DIV_CHK;
            ST_DIV_CHK:   state_next = alu_carry ? ST_OUT : ST_DIV;
            ST_DIV:       if (cnt_reg == '0) state_next = ST_FINAL;
            ST_FINAL:     state_next = ST_OUT;
            ST_CLAMP_RD:  state_next = ST_CLAMP_LD;
            ST_CLAMP_LD:  state_next = ST_OUT;
            ST_OUT:       if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: ready, read address, unit operands
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        rd_addr  = j_reg;
        alu_a    = '0;
        alu_b    = '0;
        alu_op   = OP_SUB;
        case (state_reg)
            ST_QCHK:
            begin
                alu_a = UW'(cfg_thr_reg);
                alu_b = UW'(q_reg);
            end
            ST_SRCH_ADDR:
            begin
                rd_addr = mid;
            end
            ST_SRCH_CMP:
            begin
                rd_addr = mid;
                alu_a   = UW'(q_reg);
                alu_b   = UW'(rd_pos);
            end
            ST_RD_J:
            begin
                rd_addr = j_reg;
            end
            ST_RD_K:
            begin
                rd_addr = k_reg;
            end
            ST_DQ_P:
            begin
                alu_a = UW'(q_reg);
                alu_b = UW'(bpj_reg);
            end
            ST_DQ_N:
            begin
                alu_a = UW'(bpj_reg);
                alu_b = UW'(q_reg);
            end
            ST_DR_P:
            begin
                alu_a = UW'(bpk_reg);
                alu_b = UW'(bpj_reg);
            end
            ST_DR_N:
            begin
                alu_a = UW'(bpj_reg);
                alu_b = UW'(bpk_reg);
            end
            ST_DV_P:
            begin
                alu_a = vk_ext;
                alu_b = vj_ext;
            end
            ST_DV_N:
            begin
                alu_a = vj_ext;
                alu_b = vk_ext;
            end
            ST_MUL:
            begin
                alu_op = OP_ADD;
                alu_a  = UW'(prod_reg[PW-1:MAG_W]);
                alu_b  = prod_reg[0] ? UW'(mag_dv_reg) : '0;
            end
            ST_DIV_CHK:
            begin
                alu_a = UW'(prod_reg[PW-1:VW]);
                alu_b = UW'(mag_dr_reg);
            end
            ST_DIV:
            begin
                alu_a = UW'({rem_reg, dvd_reg[VW-1]});
                alu_b = UW'(mag_dr_reg);
            end
            ST_FINAL:
            begin
                alu_op = neg_reg ? OP_SUB : OP_ADD;
                alu_a  = vj_ext;
                alu_b  = UW'(dvd_reg);
            end
            ST_CLAMP_RD, ST_CLAMP_LD:
            begin
                rd_addr = nm1;
            end
            default:
            begin
                rd_addr = j_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cfg_count_reg <= COUNT_RESET;
            cfg_thr_reg   <= '1;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ENTRY_COUNT:     cfg_count_reg <= cfg_data[COUNT_W-1:0];
                    REG_CLAMP_THRESHOLD: cfg_thr_reg   <= cfg_data;
                    default:             cfg_thr_reg   <= cfg_thr_reg;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (query_xfer)
                begin
                    q_reg <= in_q;
                    j_reg <= '0;
                    k_reg <= nm1;
                end
            end
            // narrow the bracket
            ST_SRCH_CMP:
            begin
                if (!alu_carry)
                begin
                    k_reg <= mid;
                end
                else
                begin
                    j_reg <= mid;
                end
            end
            ST_RD_K:
            begin
                bpj_reg <= rd_pos;
                vj_reg  <= rd_val;
            end
            ST_LD_K:
            begin
                bpk_reg <= rd_pos;
                vk_reg  <= rd_val;
            end
            // differences and their signs
            ST_DQ_P:
            begin
                tmp_reg <= alu_sum;
                neg_reg <= alu_sum[UW-1];
            end
            ST_DQ_N:
            begin
                mag_dq_reg <= sel_mag;
            end
            ST_DR_P:
            begin
                tmp_reg <= alu_sum;
                neg_reg <= neg_reg ^ alu_sum[UW-1];
            end
            ST_DR_N:
            begin
                mag_dr_reg <= sel_mag;
                // equal breakpoints give the left value
                if (sel_mag == '0)
                begin
                    dvd_reg <= '0;
                    neg_reg <= 1'b0;
                end
            end
            ST_DV_P:
            begin
                tmp_reg <= alu_sum;
                neg_reg <= neg_reg ^ alu_sum[UW-1];
            end
            ST_DV_N:
            begin
                mag_dv_reg <= sel_mag_dv;
                prod_reg   <= PW'(mag_dq_reg);
                cnt_reg    <= CNTW'(MAG_W - 1);
            end
            // shift-add multiply, multiplier bits from the low end
            ST_MUL:
            begin
                prod_reg <= {alu_sum[VW+1:0], prod_reg[MAG_W-1:1]};
                cnt_reg  <= cnt_reg - CNTW'(1);
            end
            // quotient too large for the value range saturates
            ST_DIV_CHK:
            begin
                if (alu_carry)
                begin
                    res_reg       <= neg_reg ? VMIN : VMAX;
                    res_sat_reg   <= 1'b1;
                    res_clamp_reg <= 1'b0;
                end
                else
                begin
                    rem_reg <= prod_reg[VW+MAG_W-1:VW];
                    dvd_reg <= prod_reg[VW-1:0];
                    cnt_reg <= CNTW'(VW - 1);
                end
            end
            // restoring divide, quotient bits shift in behind the dividend
            ST_DIV:
            begin
                rem_reg <= alu_carry ? alu_sum[MAG_W-1:0]
                                     : {rem_reg[MAG_W-2:0], dvd_reg[VW-1]};
                dvd_reg <= {dvd_reg[VW-2:0], alu_carry};
                cnt_reg <= cnt_reg - CNTW'(1);
            end
            // add quotient to left value and saturate
            ST_FINAL:
            begin
                res_reg       <= in_range ? alu_sum[VW-1:0] : (alu_sum[UW-1] ? VMIN : VMAX);
                res_sat_reg   <= !in_range;
                res_clamp_reg <= 1'b0;
            end
            ST_CLAMP_LD:
            begin
                res_reg       <= rd_val;
                res_sat_reg   <= 1'b0;
                res_clamp_reg <= 1'b1;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_value_reg <= res_reg;
                    out_clamp_reg <= res_clamp_reg;
                    out_sat_reg   <= res_sat_reg;
                end
            end
            default:
            begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end

    // result port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_value_reg);
    assign m_tuser  = {out_sat_reg, out_clamp_reg};

    // a load transfer never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_xfer && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared after a load transfer");

    // a query blocks further input while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        query_xfer |=> !s_tready)
        else $error("input ready while a query is in work");

    // a clamped result is never saturated
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("clamped and saturated both set");

    // bisection bracket stays ordered
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_CMP) |-> (k_reg > j_reg))
        else $error("bisection bracket out of order");

endmodule
